FILE: rtl/core/linear_hash_dedup_insert_top_assert.svh
// Assertion macros for the dedup insert block
`ifndef LINEAR_HASH_DEDUP_INSERT_TOP_ASSERT_SVH
`define LINEAR_HASH_DEDUP_INSERT_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define LHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent implies consequent in the following cycle
`define LHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/core/lhd_pkg.sv
package lhd_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int SLOTS       = 8;
  localparam int KEY_W       = 31;
  localparam int SLOT_W      = 3;
  localparam int SCNT_W      = 4;
  localparam int BKT_W       = 6;
  localparam int BCNT_W      = 7;
  localparam int LVL_W       = 3;
  localparam int REC_W       = 10;
  localparam int CAP_W       = 4;
  localparam int ADDR_W      = BKT_W + SLOT_W;

  localparam logic [SCNT_W-1:0] SCAN_END = SCNT_W'(SLOTS + 1);
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(8);
  localparam logic STATUS_NEW  = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_SPLIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic commit;
    logic split;
  } cmd_t;

  typedef struct packed {
    logic              scan_done;
    logic              dup;
    logic              full;
    logic              need_split;
    logic              out_free;
    logic [BCNT_W-1:0] bucket_count;
  } stat_t;

  function automatic logic [BKT_W-1:0] hash_key(
    input logic [KEY_W-1:0]  key,
    input logic [LVL_W-1:0]  lvl,
    input logic [BKT_W-1:0]  sp,
    input logic [BCNT_W-1:0] bc
  );
    logic [7:0] k;
    logic [7:0] h;
    k = {1'b0, key[6:0]};
    h = k & ((8'd1 << lvl) - 8'd1);
    if (h < {2'b00, sp}) begin
      h = k & ((8'd1 << ({1'b0, lvl} + 4'd1)) - 8'd1);
    end
    if (h >= {1'b0, bc}) begin
      h = 8'd0;
    end
    return h[BKT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/lhd_ctrl.sv
module lhd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lhd_pkg::stat_t stat,
  output lhd_pkg::cmd_t  cmd
);

  lhd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lhd_pkg::ST_IDLE: begin
        if (in_valid) state_next = lhd_pkg::ST_LOOK;
      end
      lhd_pkg::ST_LOOK: begin
        if (stat.scan_done) state_next = lhd_pkg::ST_DECIDE;
      end
      lhd_pkg::ST_DECIDE: begin
        if (stat.dup) begin
          state_next = lhd_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          if (!stat.full && stat.need_split) state_next = lhd_pkg::ST_SPLIT;
          else state_next = lhd_pkg::ST_IDLE;
        end
      end
      lhd_pkg::ST_SPLIT: begin
        if (stat.scan_done) state_next = lhd_pkg::ST_IDLE;
      end
      default: state_next = lhd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      lhd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      lhd_pkg::ST_LOOK:   cmd.look = 1'b1;
      lhd_pkg::ST_DECIDE: cmd.commit = !stat.dup && stat.out_free;
      lhd_pkg::ST_SPLIT:  cmd.split = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/lhd_datapath.sv
module lhd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lhd_pkg::cmd_t               cmd,
  input  logic [lhd_pkg::KEY_W-1:0]   in_key,
  input  logic                        cfg_wr_en,
  input  logic [lhd_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [lhd_pkg::KEY_W-1:0]   out_key,
  output logic                        out_status,
  output lhd_pkg::stat_t              stat
);

  logic [lhd_pkg::CAP_W-1:0]  cap;
  logic [lhd_pkg::LVL_W-1:0]  level;
  logic [lhd_pkg::BKT_W-1:0]  sp;
  logic [lhd_pkg::BCNT_W-1:0] bc;
  logic [lhd_pkg::REC_W-1:0]  rc;
  logic [lhd_pkg::KEY_W-1:0]  key;
  logic [lhd_pkg::BKT_W-1:0]  bkt;
  logic [lhd_pkg::BKT_W-1:0]  fresh;
  logic [lhd_pkg::SLOT_W-1:0] put;
  logic [lhd_pkg::SCNT_W-1:0] scnt;
  logic                       pend;
  logic [lhd_pkg::SLOT_W-1:0] pslot;
  logic                       dup;
  logic [lhd_pkg::SLOTS-1:0]  row;
  logic [lhd_pkg::SLOTS-1:0]  frow;
  logic [lhd_pkg::SLOTS-1:0]  vmem [lhd_pkg::MAX_BUCKETS];
  logic [lhd_pkg::KEY_W-1:0]  mem [lhd_pkg::MAX_BUCKETS * lhd_pkg::SLOTS];
  logic [lhd_pkg::KEY_W-1:0]  rd_data;

  logic [lhd_pkg::BKT_W-1:0]  in_bkt;
  logic [lhd_pkg::SLOTS-1:0]  row_ins;
  logic                       vwe;
  logic [lhd_pkg::BKT_W-1:0]  vaddr;
  logic [lhd_pkg::SLOTS-1:0]  vdata;
  logic [lhd_pkg::SLOT_W-1:0] free_slot;
  logic                       full;
  logic                       issue;
  logic [lhd_pkg::ADDR_W-1:0] raddr;
  logic                       mem_we;
  logic [lhd_pkg::ADDR_W-1:0] waddr;
  logic [lhd_pkg::KEY_W-1:0]  wdata;
  logic [lhd_pkg::REC_W-1:0]  rc_inc;
  logic [11:0]                load;
  logic [10:0]                capbc;
  logic [12:0]                limit;
  logic                       need_split;
  logic                       move;
  logic                       wrap;

  assign in_bkt = lhd_pkg::hash_key(in_key, level, sp, bc);
  assign full = &row;
  assign row_ins = row | (lhd_pkg::SLOTS'(1) << free_slot);
  assign issue = (cmd.look || cmd.split) && (scnt < lhd_pkg::SCNT_W'(lhd_pkg::SLOTS));
  assign raddr = {bkt, scnt[lhd_pkg::SLOT_W-1:0]};
  assign rc_inc = rc + lhd_pkg::REC_W'(1);
  assign load = {rc_inc, 2'b00};
  assign capbc = lhd_pkg::CAP_W'(cap) * bc;
  assign limit = {2'b00, capbc} + {1'b0, capbc, 1'b0};
  assign need_split = (bc < lhd_pkg::BCNT_W'(lhd_pkg::MAX_BUCKETS)) &&
                      ({1'b0, load} >= limit);
  assign move = cmd.split && pend && row[pslot] &&
                (lhd_pkg::hash_key(rd_data, level, sp, bc) != bkt);
  assign wrap = ({2'b00, sp} + 8'd1) >= (8'd1 << level);

  always_comb begin
    free_slot = '0;
    for (int i = lhd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!row[i]) free_slot = lhd_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr = {bkt, free_slot};
    wdata = key;
    if (cmd.commit && !full) begin
      mem_we = 1'b1;
    end else if (move) begin
      mem_we = 1'b1;
      waddr = {fresh, put};
      wdata = rd_data;
    end
  end

  always_comb begin
    vwe = 1'b0;
    vaddr = bkt;
    vdata = row_ins;
    if (rst) begin
      vwe = 1'b1;
      vaddr = '0;
      vdata = '0;
    end else if (cmd.commit && !full) begin
      vwe = 1'b1;
    end else if (cmd.split && (scnt == '0)) begin
      vwe = 1'b1;
      vaddr = fresh;
      vdata = '0;
    end else if (move) begin
      vwe = 1'b1;
      vaddr = fresh;
      vdata = frow | (lhd_pkg::SLOTS'(1) << put);
    end else if (cmd.split && (scnt == lhd_pkg::SCAN_END)) begin
      vwe = 1'b1;
      vdata = row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (issue) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= lhd_pkg::CAP_RESET;
      level <= '0;
      sp <= '0;
      bc <= lhd_pkg::BCNT_W'(1);
      rc <= '0;
      out_valid <= 1'b0;
      scnt <= '0;
      pend <= 1'b0;
      dup <= 1'b0;
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      if (cmd.accept) begin
        key <= in_key;
        bkt <= in_bkt;
        row <= vmem[in_bkt];
        scnt <= '0;
        pend <= 1'b0;
        dup <= 1'b0;
      end
      if (cmd.look || cmd.split) begin
        if (scnt != lhd_pkg::SCAN_END) scnt <= scnt + lhd_pkg::SCNT_W'(1);
        pend <= issue;
        pslot <= scnt[lhd_pkg::SLOT_W-1:0];
      end
      if (cmd.look && pend && row[pslot] && (rd_data == key)) dup <= 1'b1;
      if (cmd.commit) begin
        out_valid <= 1'b1;
        out_key <= key;
        out_status <= full ? lhd_pkg::STATUS_FULL : lhd_pkg::STATUS_NEW;
        if (!full) begin
          rc <= rc_inc;
          if (need_split) begin
            bkt <= sp;
            row <= (sp == bkt) ? row_ins : vmem[sp];
            frow <= '0;
            fresh <= bc[lhd_pkg::BKT_W-1:0];
            put <= '0;
            scnt <= '0;
            pend <= 1'b0;
            bc <= bc + lhd_pkg::BCNT_W'(1);
            if (wrap) begin
              level <= level + lhd_pkg::LVL_W'(1);
              sp <= '0;
            end else begin
              sp <= sp + lhd_pkg::BKT_W'(1);
            end
          end
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (move) begin
        frow[put] <= 1'b1;
        row[pslot] <= 1'b0;
        put <= put + lhd_pkg::SLOT_W'(1);
      end
    end
  end

  always_comb begin
    stat.scan_done = (scnt == lhd_pkg::SCAN_END);
    stat.dup = dup;
    stat.full = full;
    stat.need_split = need_split;
    stat.out_free = !out_valid || out_ready;
    stat.bucket_count = bc;
  end

endmodule

FILE: rtl/core/linear_hash_dedup_insert_top.sv
// Each request runs a bucket scan, one slot per cycle, then a decide step that
// waits while the output is held. An insert that splits a bucket adds a scan
// of the split bucket. A new key is taken only once the previous one is done.
// The slot memory has one read port and one write port.
// Reset: rst, synchronous, active high; clears level, split pointer, counts, the
// valid row of bucket 0 and sets bucket_capacity to 8. No clearing pass is needed.
module linear_hash_dedup_insert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] out_key
  output logic        m_axis_tuser,   // [0] status
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  `include "linear_hash_dedup_insert_top_assert.svh"

  lhd_pkg::cmd_t  cmd;
  lhd_pkg::stat_t stat;
  logic [lhd_pkg::KEY_W-1:0] out_key;

  lhd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lhd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_key      (s_axis_tdata[lhd_pkg::KEY_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_key     (out_key),
    .out_status  (m_axis_tuser),
    .stat        (stat)
  );

  assign m_axis_tdata = {1'b0, out_key};

  `LHD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LHD_ASSERT_NOW(a_commit_out_free, cmd.commit, !m_axis_tvalid || m_axis_tready)
  `LHD_ASSERT_NOW(a_bucket_limit, 1'b1,
                  stat.bucket_count <= lhd_pkg::BCNT_W'(lhd_pkg::MAX_BUCKETS))

endmodule
